@@ rtl/core/memory_map_page_query_assert.svh @@
// ----------------------------------------------------------------------------
// memory_map_page_query_assert.svh
// Assertion macros used by the checker of the memory map page query block.
// ----------------------------------------------------------------------------
`ifndef MEMORY_MAP_PAGE_QUERY_ASSERT_SVH
`define MEMORY_MAP_PAGE_QUERY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mmpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mmpq_pkg
// Shared codes and controller/datapath interface types for the memory map
// page query block.
// ----------------------------------------------------------------------------
package mmpq_pkg;

  // Input item operation codes.
  localparam logic [2:0] FUNC_WRITE = 3'd0;
  localparam logic [2:0] FUNC_ADDR  = 3'd1;
  localparam logic [2:0] FUNC_RANGE = 3'd2;
  localparam logic [2:0] FUNC_FIRST = 3'd3;
  localparam logic [2:0] FUNC_NEXT  = 3'd4;
  localparam logic [2:0] FUNC_PREV  = 3'd5;

  // Walk modes: what each table entry is tested for during one pass.
  localparam logic [2:0] MODE_ADDR  = 3'd0;
  localparam logic [2:0] MODE_RANGE = 3'd1;
  localparam logic [2:0] MODE_FIRST = 3'd2;
  localparam logic [2:0] MODE_FITS  = 3'd3;
  localparam logic [2:0] MODE_NEXT  = 3'd4;
  localparam logic [2:0] MODE_PREV  = 3'd5;

  // Result selection codes used when a query finishes.
  localparam logic [2:0] SEL_ZERO   = 3'd0;
  localparam logic [2:0] SEL_ADDR   = 3'd1;
  localparam logic [2:0] SEL_CUR    = 3'd2;
  localparam logic [2:0] SEL_PT     = 3'd3;
  localparam logic [2:0] SEL_BEST_N = 3'd4;
  localparam logic [2:0] SEL_BEST_P = 3'd5;
  localparam logic [2:0] SEL_HIT    = 3'd6;
  localparam logic [2:0] SEL_FIRST  = 3'd7;

  // Index of the last setup step before a walk.
  localparam logic [2:0] SETUP_LAST = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       wr_en;
    logic       setup_en;
    logic [2:0] setup_step;
    logic       prev;
    logic       pass_start;
    logic [2:0] mode;
    logic       rd_en;
    logic       finish;
    logic [2:0] sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;
    logic addr_zero;
    logic cur_ovf;
    logic cur_lt_ps;
    logic busy;
    logic hit;
  } status_t;

endpackage

@@ rtl/core/mmpq_datapath.sv @@
// ----------------------------------------------------------------------------
// mmpq_datapath
// Descriptor memory, query setup arithmetic, per-entry evaluation pipeline,
// accumulators and the result register.
// ----------------------------------------------------------------------------
module mmpq_datapath
  import mmpq_pkg::*;
#(
  parameter int TABLE_DEPTH     = 64,
  parameter int DESC_PAGE_SHIFT = 12,
  parameter int AW              = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  input  logic [AW-1:0] rd_addr,
  input  logic [5:0]    in_entry_index,
  input  logic [3:0]    in_entry_type,
  input  logic [63:0]   in_entry_start,
  input  logic [63:0]   in_entry_pages,
  input  logic [63:0]   in_address,
  input  logic [63:0]   in_length,
  output status_t       status,
  output logic          out_found,
  output logic [63:0]   out_result_address
);

  // Descriptor memory.
  logic [3:0]  mem_type  [TABLE_DEPTH];
  logic [63:0] mem_start [TABLE_DEPTH];
  logic [63:0] mem_pages [TABLE_DEPTH];

  logic [10:0]   wr_idx_ext;
  logic [AW-1:0] wr_addr;
  logic          wr_ok;

  assign wr_idx_ext = 11'(in_entry_index);
  assign wr_addr    = wr_idx_ext[AW-1:0];
  assign wr_ok      = 32'(in_entry_index) < TABLE_DEPTH;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem_type[wr_addr]  <= in_entry_type;
      mem_start[wr_addr] <= in_entry_start;
      mem_pages[wr_addr] <= in_entry_pages;
    end
  end

  // Registered read port.
  logic [3:0]  a_type_r;
  logic [63:0] a_start_r, a_pages_r;
  logic        va_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_type_r  <= mem_type[rd_addr];
      a_start_r <= mem_start[rd_addr];
      a_pages_r <= mem_pages[rd_addr];
    end
  end

  // Query operands and setup values.
  logic [63:0] a_r, ps_r, psm1_r, re_r, cur_r, pt_r, base_r, bend_r, alnxt_r, candpp_r;
  logic        ovf_r, ltps_r, is_prev_r;
  logic [2:0]  mode_r;
  logic [64:0] cur_sum;

  assign cur_sum = {1'b0, cur_r} + {1'b0, ps_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r  <= in_address;
      ps_r <= in_length;
    end
    if (cmd.pass_start) begin
      mode_r <= cmd.mode;
    end
    if (cmd.setup_en) begin
      unique case (cmd.setup_step)
        3'd0: begin
          psm1_r    <= ps_r - 64'd1;
          re_r      <= a_r + ps_r;
          is_prev_r <= cmd.prev;
        end
        3'd1: cur_r <= a_r & ~psm1_r;
        3'd2: begin
          ovf_r  <= cur_sum[64];
          ltps_r <= cur_r < ps_r;
          pt_r   <= is_prev_r ? (cur_r - ps_r) : cur_sum[63:0];
        end
        3'd3: begin
          base_r  <= pt_r & ~psm1_r;
          alnxt_r <= pt_r + psm1_r;
        end
        3'd4: begin
          bend_r  <= base_r + ps_r;
          alnxt_r <= alnxt_r & ~psm1_r;
        end
        default: candpp_r <= alnxt_r + ps_r;
      endcase
    end
  end

  // Stage B: entry end and unmasked aligned start.
  logic        vb_r, b_use_r, b_pnz_r;
  logic [63:0] b_start_r, b_end_r, b_fsum_r;

  always_ff @(posedge clk) begin
    b_use_r   <= (a_type_r >= 4'd1) && (a_type_r <= 4'd7);
    b_pnz_r   <= a_pages_r != 64'd0;
    b_start_r <= a_start_r;
    b_end_r   <= a_start_r + (a_pages_r << DESC_PAGE_SHIFT);
    b_fsum_r  <= a_start_r + psm1_r;
  end

  // Stage C: aligned first page, its end, and the last whole page.
  logic        vc_r, c_use_r, c_pnz_r;
  logic [63:0] c_start_r, c_end_r, c_first_r, c_fpp_r, c_last_r;
  logic [63:0] b_first;

  assign b_first = b_fsum_r & ~psm1_r;

  always_ff @(posedge clk) begin
    c_use_r   <= b_use_r;
    c_pnz_r   <= b_pnz_r;
    c_start_r <= b_start_r;
    c_end_r   <= b_end_r;
    c_first_r <= b_first;
    c_fpp_r   <= b_first + ps_r;
    c_last_r  <= (b_end_r - ps_r) & ~psm1_r;
  end

  // Stage D: per-mode test of one entry.
  logic        vd_r, d_hit_r;
  logic [63:0] d_cand_r;
  logic        hit_c, base_ok;
  logic [63:0] cand_c;

  always_comb begin
    base_ok = c_use_r && c_pnz_r && (c_end_r >= ps_r) && (c_fpp_r <= c_end_r);
    hit_c   = 1'b0;
    cand_c  = c_start_r;
    unique case (mode_r)
      MODE_ADDR:  hit_c = c_use_r && (a_r >= c_start_r) && (a_r < c_end_r);
      MODE_RANGE: hit_c = c_use_r && (a_r >= c_start_r) && (re_r <= c_end_r);
      MODE_FIRST: hit_c = c_use_r;
      MODE_FITS:  hit_c = c_use_r && c_pnz_r && (base_r >= c_start_r) && (bend_r <= c_end_r);
      MODE_NEXT: begin
        if (pt_r <= c_first_r) begin
          cand_c = c_first_r;
          hit_c  = base_ok;
        end else if (pt_r < c_end_r) begin
          cand_c = alnxt_r;
          hit_c  = base_ok && (candpp_r <= c_end_r);
        end
      end
      MODE_PREV: begin
        if (cur_r > c_last_r) begin
          cand_c = c_last_r;
          hit_c  = base_ok && (c_last_r >= c_first_r) && (cur_r > c_first_r);
        end else begin
          cand_c = pt_r;
          hit_c  = base_ok && (c_last_r >= c_first_r) && (cur_r > c_first_r)
                   && (pt_r >= c_first_r);
        end
      end
      default: hit_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    d_hit_r  <= hit_c;
    d_cand_r <= cand_c;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= cmd.rd_en;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // Accumulators for one pass.
  logic        acc_hit_r;
  logic [63:0] acc_val_r, best_r;

  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      acc_hit_r <= 1'b0;
      acc_val_r <= 64'd0;
      best_r    <= (cmd.mode == MODE_NEXT) ? cur_r : 64'd0;
    end else if (vd_r && d_hit_r) begin
      unique case (mode_r)
        MODE_FIRST: begin
          if (!acc_hit_r) begin
            acc_hit_r <= 1'b1;
            acc_val_r <= d_cand_r;
          end
        end
        MODE_NEXT: begin
          if ((d_cand_r > cur_r) && ((best_r == cur_r) || (d_cand_r < best_r))) begin
            best_r <= d_cand_r;
          end
        end
        MODE_PREV: begin
          if ((d_cand_r < cur_r) && (d_cand_r > best_r)) begin
            best_r <= d_cand_r;
          end
        end
        default: acc_hit_r <= 1'b1;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found          <= 1'b0;
      out_result_address <= 64'd0;
      unique case (cmd.sel)
        SEL_ZERO:   out_result_address <= 64'd0;
        SEL_ADDR:   out_result_address <= a_r;
        SEL_CUR:    out_result_address <= cur_r;
        SEL_PT:     out_result_address <= pt_r;
        SEL_BEST_N: out_result_address <= best_r;
        SEL_BEST_P: out_result_address <= (best_r != 64'd0) ? best_r : cur_r;
        SEL_HIT:    out_found          <= acc_hit_r;
        SEL_FIRST:  out_result_address <= acc_val_r;
        default:    out_result_address <= 64'd0;
      endcase
    end
  end

  // Status to the controller.
  assign status.len_zero  = ps_r == 64'd0;
  assign status.addr_zero = a_r == 64'd0;
  assign status.cur_ovf   = ovf_r;
  assign status.cur_lt_ps = ltps_r;
  assign status.busy      = va_r | vb_r | vc_r | vd_r;
  assign status.hit       = acc_hit_r;

endmodule

@@ rtl/core/mmpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmpq_ctrl
// Controller state machine: accepts items, sequences setup, table walks and
// the second pass of page searches, and drives the result handshake.
// ----------------------------------------------------------------------------
module mmpq_ctrl
  import mmpq_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int AW          = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_func,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_descriptor_count,
  output logic          out_valid,
  input  logic          out_ready,
  input  status_t       status,
  output cmd_t          cmd,
  output logic [AW-1:0] rd_addr
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [2:0]    sel_r, sel_nxt;
  logic          pass_r, pass_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [6:0]    count_r;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] walk_n;
  logic          n_zero;

  // Descriptor count register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 7'd0;
    end else if (cfg_valid) begin
      count_r <= cfg_descriptor_count;
    end
  end

  // Walk length is the count clipped to the table depth.
  assign walk_n  = (32'(count_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_r);
  assign n_zero  = walk_n == '0;
  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign rd_addr   = ptr_r[AW-1:0];

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    step_nxt      = step_r;
    sel_nxt       = sel_r;
    pass_nxt      = pass_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd            = '0;
    cmd.setup_step = step_r;
    cmd.prev       = func_r == FUNC_PREV;
    cmd.sel        = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_WRITE) begin
            cmd.wr_en = 1'b1;
          end else if (in_func <= FUNC_PREV) begin
            cmd.load  = 1'b1;
            func_nxt  = in_func;
            step_nxt  = 3'd0;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup_en = 1'b1;
        if (step_r == SETUP_LAST) begin
          state_nxt = ST_CHECK;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_CHECK: begin
        pass_nxt  = 1'b0;
        ptr_nxt   = '0;
        state_nxt = ST_WALK;
        priority case (func_r)
          FUNC_ADDR: begin
            cmd.pass_start = 1'b1;
            cmd.mode       = MODE_ADDR;
          end
          FUNC_RANGE: begin
            if (status.len_zero) begin
              sel_nxt   = SEL_ZERO;
              state_nxt = ST_FINISH;
            end else begin
              cmd.pass_start = 1'b1;
              cmd.mode       = MODE_RANGE;
            end
          end
          FUNC_FIRST: begin
            cmd.pass_start = 1'b1;
            cmd.mode       = MODE_FIRST;
          end
          FUNC_NEXT: begin
            if (n_zero || status.len_zero) begin
              sel_nxt   = SEL_ADDR;
              state_nxt = ST_FINISH;
            end else if (status.cur_ovf) begin
              sel_nxt   = SEL_CUR;
              state_nxt = ST_FINISH;
            end else begin
              cmd.pass_start = 1'b1;
              cmd.mode       = MODE_FITS;
            end
          end
          default: begin
            if (n_zero || status.len_zero || status.addr_zero) begin
              sel_nxt   = SEL_ADDR;
              state_nxt = ST_FINISH;
            end else if (status.cur_lt_ps) begin
              sel_nxt   = SEL_CUR;
              state_nxt = ST_FINISH;
            end else begin
              cmd.pass_start = 1'b1;
              cmd.mode       = MODE_FITS;
            end
          end
        endcase
      end
      ST_WALK: begin
        if (ptr_r < walk_n) begin
          cmd.rd_en = 1'b1;
          ptr_nxt   = ptr_r + CW'(1);
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = ST_FINISH;
          priority case (func_r)
            FUNC_ADDR, FUNC_RANGE: sel_nxt = SEL_HIT;
            FUNC_FIRST:            sel_nxt = SEL_FIRST;
            default: begin
              if (pass_r) begin
                sel_nxt = (func_r == FUNC_NEXT) ? SEL_BEST_N : SEL_BEST_P;
              end else if (status.hit) begin
                sel_nxt = SEL_PT;
              end else begin
                cmd.pass_start = 1'b1;
                cmd.mode       = (func_r == FUNC_NEXT) ? MODE_NEXT : MODE_PREV;
                pass_nxt       = 1'b1;
                ptr_nxt        = '0;
                state_nxt      = ST_WALK;
              end
            end
          endcase
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      func_r      <= FUNC_WRITE;
      step_r      <= 3'd0;
      sel_r       <= SEL_ZERO;
      pass_r      <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      func_r      <= func_nxt;
      step_r      <= step_nxt;
      sel_r       <= sel_nxt;
      pass_r      <= pass_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

endmodule

@@ rtl/core/memory_map_page_query.sv @@
// ----------------------------------------------------------------------------
// memory_map_page_query
// Memory descriptor table with address, range, first-usable and page queries.
// ----------------------------------------------------------------------------
// A write item (func 0) loads one descriptor. A query item takes six setup
// steps, then walks the first n descriptors, where n is the descriptor count
// clipped to TABLE_DEPTH, at one entry per cycle through the single read port
// of the descriptor memory, followed by a drain of the evaluation pipeline and
// the load of the result register; that is the whole sequence for address
// checks, range checks and first-usable queries. Next and previous page
// searches walk the table once to test the neighbor page and, when it does
// not fit, a second time for the nearest candidate; early exits (empty map,
// zero size, top or bottom edge) finish right after setup. One item is worked
// on at a time; a waiting result does not block acceptance of the next item.
module memory_map_page_query
  import mmpq_pkg::*;
#(
  parameter int TABLE_DEPTH     = 64,
  parameter int DESC_PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [5:0]  in_entry_index,
  input  logic [3:0]  in_entry_type,
  input  logic [63:0] in_entry_start,
  input  logic [63:0] in_entry_pages,
  input  logic [63:0] in_address,
  input  logic [63:0] in_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_descriptor_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_result_address
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] rd_addr;

  // Sequencing.
  mmpq_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_descriptor_count(cfg_descriptor_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .cmd                 (cmd),
    .rd_addr             (rd_addr)
  );

  // Storage and arithmetic.
  mmpq_datapath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .DESC_PAGE_SHIFT(DESC_PAGE_SHIFT),
    .AW             (AW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .in_entry_index    (in_entry_index),
    .in_entry_type     (in_entry_type),
    .in_entry_start    (in_entry_start),
    .in_entry_pages    (in_entry_pages),
    .in_address        (in_address),
    .in_length         (in_length),
    .status            (status),
    .out_found         (out_found),
    .out_result_address(out_result_address)
  );

endmodule

@@ rtl/core/mmpq_checker.sv @@
// ----------------------------------------------------------------------------
// mmpq_checker
// Port-level checks of the memory map page query block, bound to its top.
// ----------------------------------------------------------------------------
`include "memory_map_page_query_assert.svh"

module mmpq_checker
  import mmpq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [63:0] out_result_address
);

  // A stalled result holds its payload.
  `MMPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_result_address), "stalled result changed")

  // A check answer never carries an address.
  `MMPQ_ASSERT_NOW(a_found_addr, out_valid && out_found, out_result_address == 64'd0, "found with nonzero address")

  // A write item produces no result.
  `MMPQ_ASSERT_NEXT(a_write_silent, in_valid && in_ready && (in_func == FUNC_WRITE) && !out_valid, !out_valid, "write item produced a result")

endmodule

bind memory_map_page_query mmpq_checker u_mmpq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_func           (in_func),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_found         (out_found),
  .out_result_address(out_result_address)
);
